>>> hw/rtl/mtel_pkg.sv
// Shared types, constants and helpers of the move-to-end ordered list.
// No dependencies; every other file but mtel_ram takes names from here by scope.
package mtel_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int ID_W         = 7;
   localparam int LINK_DEPTH   = MAX_ELEMENTS + 1;
   localparam int MODE_W       = 2;
   localparam int RESET_COUNT  = (MAX_ELEMENTS < 64) ? MAX_ELEMENTS : 64;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_ADDR_W-3:0] REG_ELEMENT_COUNT = '0;

   typedef enum logic [MODE_W-1:0] {
      MODE_LEFT  = 2'd0,
      MODE_RIGHT = 2'd1,
      MODE_DUMP  = 2'd2,
      MODE_INIT  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [ID_W-1:0] count;
      logic            rebuild;
   } cfg_type;

   function automatic logic [ID_W-1:0] fix_id(input logic [ID_W-1:0] v);
      return (v <= ID_W'(MAX_ELEMENTS)) ? v : '0;
   endfunction

endpackage

>>> hw/rtl/mtel_ifs.sv
// Handshake interfaces of the request and response channels.
// Depends on mtel_pkg for field widths.
interface mtel_req_if;
   logic                         valid;
   logic                         ready;
   logic [mtel_pkg::MODE_W-1:0]  mode;
   logic [mtel_pkg::ID_W-1:0]    element;

   modport source (output valid, output mode, output element, input ready);
   modport sink   (input valid, input mode, input element, output ready);
endinterface

interface mtel_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mtel_pkg::ID_W-1:0]    element_id;
   logic                         is_last;

   modport source (output valid, output element_id, output is_last, input ready);
   modport sink   (input valid, input element_id, input is_last, output ready);
endinterface

>>> hw/rtl/move_to_end_ordered_list.sv
// Top level of the move-to-end ordered list.
// Depends on mtel_pkg, mtel_ifs, mtel_csr and mtel_seq.
//
//   channel   direction  beat carries
//   req_bus   in         mode, element
//   rsp_bus   out        element_id, is_last
//   apb       in/out     element_count at byte address 0
//
// A move returns to ready via ST_MRD, ST_UNL, ST_END, ST_W1, ST_W2: a read,
// an unlink write, a wait and two end writes on the two single-write RAMs.
// A dump reads the head, then ST_DRD, ST_DNX, ST_DOUT per id, one RAM read
// per id. Init, a count write and reset sweep every table entry. Requests
// are taken only while idle; a stalled rsp_bus holds the dump at its next id.
module move_to_end_ordered_list (
   input  logic                            clock,
   input  logic                            reset,
   mtel_req_if.sink                        req_bus,
   mtel_rsp_if.source                      rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mtel_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mtel_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mtel_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   mtel_pkg::cfg_type cfg;

   mtel_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mtel_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule

>>> hw/rtl/mtel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/mtel_csr.sv
// APB-style register file holding element_count.
// Depends on mtel_pkg; raises a rebuild request on every count write.
module mtel_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mtel_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mtel_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mtel_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output mtel_pkg::cfg_type                   cfg
);

   logic [mtel_pkg::ID_W-1:0]          count_ff;
   logic [mtel_pkg::ID_W-1:0]          count_in;
   logic [mtel_pkg::ID_W-1:0]          wr_value;
   logic [mtel_pkg::CSR_ADDR_W-3:0]    reg_index;
   logic                               wr_count;

   assign reg_index = paddr[mtel_pkg::CSR_ADDR_W-1:2];
   assign wr_count  = psel && penable && pwrite &&
                      (reg_index == mtel_pkg::REG_ELEMENT_COUNT);
   assign wr_value  = pwdata[mtel_pkg::ID_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (wr_count) begin
         priority if (wr_value == '0) begin
            count_in = mtel_pkg::ID_W'(1);
         end else if (wr_value > mtel_pkg::ID_W'(mtel_pkg::MAX_ELEMENTS)) begin
            count_in = mtel_pkg::ID_W'(mtel_pkg::MAX_ELEMENTS);
         end else begin
            count_in = wr_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= mtel_pkg::ID_W'(mtel_pkg::RESET_COUNT);
      end else begin
         count_ff <= count_in;
      end
   end

   assign pready      = 1'b1;
   assign prdata      = (reg_index == mtel_pkg::REG_ELEMENT_COUNT) ?
                        mtel_pkg::CSR_DATA_W'(count_ff) : '0;
   assign cfg.count   = count_ff;
   assign cfg.rebuild = wr_count;

endmodule

>>> hw/rtl/mtel_seq.sv
// Sequencer over the next/prev link tables: sweep, move, dump.
// Depends on mtel_pkg, mtel_ifs and mtel_ram.
module mtel_seq (
   input  logic              clock,
   input  logic              reset,
   input  mtel_pkg::cfg_type cfg,
   mtel_req_if.sink          req,
   mtel_rsp_if.source        rsp
);

   typedef enum logic [11:0] {
      ST_SWEEP = 12'b000000000001,
      ST_IDLE  = 12'b000000000010,
      ST_MRD   = 12'b000000000100,
      ST_UNL   = 12'b000000001000,
      ST_END   = 12'b000000010000,
      ST_W1    = 12'b000000100000,
      ST_W2    = 12'b000001000000,
      ST_DHEAD = 12'b000010000000,
      ST_DHD   = 12'b000100000000,
      ST_DRD   = 12'b001000000000,
      ST_DNX   = 12'b010000000000,
      ST_DOUT  = 12'b100000000000
   } state_type;

   localparam int W = mtel_pkg::ID_W;

   state_type          state_ff, state_in;
   logic [W-1:0]       idx_ff, idx_in;
   mtel_pkg::mode_type mode_ff, mode_in;
   logic [W-1:0]       elem_ff, elem_in;
   logic [W-1:0]       end_ff, end_in;
   logic [W-1:0]       cur_ff, cur_in;
   logic [W-1:0]       nx_ff, nx_in;
   logic [W-1:0]       cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]       rsp_id_ff, rsp_id_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               nwe, pwe;
   logic [W-1:0]       nwaddr, nwdata, pwaddr, pwdata;
   logic [W-1:0]       nraddr, praddr, nrd, prd;
   logic [W-1:0]       nrd_fix, prd_fix;
   logic               rsp_free;
   logic               last_beat;
   mtel_pkg::mode_type req_mode;

   mtel_ram #(.WIDTH(W), .DEPTH(mtel_pkg::LINK_DEPTH)) u_next_ram (
      .clock (clock),
      .we    (nwe),
      .waddr (nwaddr),
      .wdata (nwdata),
      .raddr (nraddr),
      .rdata (nrd)
   );

   mtel_ram #(.WIDTH(W), .DEPTH(mtel_pkg::LINK_DEPTH)) u_prev_ram (
      .clock (clock),
      .we    (pwe),
      .waddr (pwaddr),
      .wdata (pwdata),
      .raddr (praddr),
      .rdata (prd)
   );

   assign nrd_fix   = mtel_pkg::fix_id(nrd);
   assign prd_fix   = mtel_pkg::fix_id(prd);
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign last_beat = (nx_ff == '0) ||
                      ({1'b0, cnt_ff} + (W+1)'(1) >= {1'b0, cfg.count});
   assign req_mode  = mtel_pkg::mode_type'(req.mode);

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.element_id = rsp_id_ff;
   assign rsp.is_last    = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      mode_in      = mode_ff;
      elem_in      = elem_ff;
      end_in       = end_ff;
      cur_in       = cur_ff;
      nx_in        = nx_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      nwe          = 1'b0;
      pwe          = 1'b0;
      nwaddr       = '0;
      nwdata       = '0;
      pwaddr       = '0;
      pwdata       = '0;
      nraddr       = '0;
      praddr       = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            nwe    = 1'b1;
            pwe    = 1'b1;
            nwaddr = idx_ff;
            pwaddr = idx_ff;
            nwdata = (idx_ff < cfg.count) ? W'(idx_ff + W'(1)) : '0;
            priority if (idx_ff == '0) begin
               pwdata = cfg.count;
            end else if (idx_ff <= cfg.count) begin
               pwdata = W'(idx_ff - W'(1));
            end else begin
               pwdata = '0;
            end
            idx_in = W'(idx_ff + W'(1));
            if (idx_ff == W'(mtel_pkg::MAX_ELEMENTS)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               mode_in = req_mode;
               elem_in = req.element;
               unique case (req_mode)
                  mtel_pkg::MODE_INIT: begin
                     idx_in   = '0;
                     state_in = ST_SWEEP;
                  end
                  mtel_pkg::MODE_DUMP: begin
                     state_in = ST_DHEAD;
                  end
                  mtel_pkg::MODE_LEFT, mtel_pkg::MODE_RIGHT: begin
                     if ((req.element != '0) && (req.element <= cfg.count)) begin
                        state_in = ST_MRD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MRD: begin
            nraddr   = elem_ff;
            praddr   = elem_ff;
            state_in = ST_UNL;
         end
         ST_UNL: begin
            nwe      = 1'b1;
            nwaddr   = prd_fix;
            nwdata   = nrd_fix;
            pwe      = 1'b1;
            pwaddr   = nrd_fix;
            pwdata   = prd_fix;
            state_in = ST_END;
         end
         ST_END: begin
            state_in = ST_W1;
         end
         ST_W1: begin
            nwe    = 1'b1;
            pwe    = 1'b1;
            nwaddr = elem_ff;
            pwaddr = elem_ff;
            if (mode_ff == mtel_pkg::MODE_LEFT) begin
               end_in = nrd_fix;
               nwdata = nrd_fix;
               pwdata = '0;
            end else begin
               end_in = prd_fix;
               nwdata = '0;
               pwdata = prd_fix;
            end
            state_in = ST_W2;
         end
         ST_W2: begin
            nwe    = 1'b1;
            pwe    = 1'b1;
            nwdata = elem_ff;
            pwdata = elem_ff;
            if (mode_ff == mtel_pkg::MODE_LEFT) begin
               nwaddr = '0;
               pwaddr = end_ff;
            end else begin
               nwaddr = end_ff;
               pwaddr = '0;
            end
            state_in = ST_IDLE;
         end
         ST_DHEAD: begin
            state_in = ST_DHD;
         end
         ST_DHD: begin
            cur_in   = nrd_fix;
            cnt_in   = '0;
            state_in = (nrd_fix == '0) ? ST_IDLE : ST_DRD;
         end
         ST_DRD: begin
            nraddr   = cur_ff;
            state_in = ST_DNX;
         end
         ST_DNX: begin
            nx_in    = nrd_fix;
            state_in = ST_DOUT;
         end
         ST_DOUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = cur_ff;
               rsp_last_in  = last_beat;
               cnt_in       = W'(cnt_ff + W'(1));
               cur_in       = nx_ff;
               state_in     = last_beat ? ST_IDLE : ST_DRD;
            end
         end
         default: begin
            idx_in   = '0;
            state_in = ST_SWEEP;
         end
      endcase

      if (cfg.rebuild) begin
         idx_in   = '0;
         state_in = ST_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      elem_ff     <= elem_in;
      end_ff      <= end_in;
      cur_ff      <= cur_in;
      nx_ff       <= nx_in;
      cnt_ff      <= cnt_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

>>> hw/rtl/mtel_checker.sv
// Port-level checks of the move-to-end ordered list, bound to the top level.
// Depends on mtel_pkg and move_to_end_ordered_list.
module mtel_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [mtel_pkg::ID_W-1:0]       rsp_element_id,
   input logic                            rsp_is_last,
   input logic                            psel,
   input logic                            penable,
   input logic                            pwrite,
   input logic [mtel_pkg::CSR_ADDR_W-1:0] paddr
);

   logic count_write;

   assign count_write = psel && penable && pwrite &&
      (paddr[mtel_pkg::CSR_ADDR_W-1:2] == mtel_pkg::REG_ELEMENT_COUNT);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_dump_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> !req_ready)
      else $error("request taken in the middle of a dump");

   a_write_sweep: assert property (@(posedge clock) disable iff (reset)
      count_write |=> !req_ready)
      else $error("ready high right after a count write");

   a_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_element_id != '0) &&
                    (rsp_element_id <= mtel_pkg::ID_W'(mtel_pkg::MAX_ELEMENTS)))
      else $error("dump id out of range");

   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response raised right after a request beat");

endmodule

bind move_to_end_ordered_list mtel_checker u_mtel_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_element_id (rsp_bus.element_id),
   .rsp_is_last    (rsp_bus.is_last),
   .psel           (psel),
   .penable        (penable),
   .pwrite         (pwrite),
   .paddr          (paddr)
);

>>> dv/tb_top.sv
// Self-checking bench for move_to_end_ordered_list: moves, dumps, inits and count writes, random stalls in most phases.
// Keeps its own copy of the link tables and checks every dump beat in order.
// Depends on mtel_pkg, mtel_ifs and the RTL top level.
module tb_top;
   import mtel_pkg::*;

   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 80;
   localparam int PHASE_ITEMS   = 49;
   localparam int PHASE_COUNT   = 9;
   localparam logic [CSR_ADDR_W-1:0] COUNT_ADDR = {REG_ELEMENT_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);

   typedef struct {
      logic [ID_W-1:0] id;
      logic            last;
   } dump_beat_type;

   class ordering_tracker;
      logic [ID_W-1:0] next_of [LINK_DEPTH];
      logic [ID_W-1:0] prev_of [LINK_DEPTH];
      logic [ID_W-1:0] count;
      dump_beat_type   pending [$];
      int              error_count;

      function new();
         count = ID_W'(RESET_COUNT);
         error_count = 0;
         relink();
      endfunction

      function void relink();
         for (int i = 0; i < LINK_DEPTH; i++) begin
            next_of[i] = '0;
            prev_of[i] = '0;
         end
         for (int i = 0; i <= int'(count); i++) begin
            next_of[i] = (i == int'(count)) ? '0 : ID_W'(i + 1);
            prev_of[i] = (i == 0) ? count : ID_W'(i - 1);
         end
      endfunction

      function void set_count(logic [CSR_DATA_W-1:0] value);
         logic [ID_W-1:0] v;
         v = value[ID_W-1:0];
         if (v == 0) v = 1;
         if (v > MAX_ELEMENTS) v = ID_W'(MAX_ELEMENTS);
         count = v;
         relink();
      endfunction

      function void note_request(mode_type m, logic [ID_W-1:0] el);
         logic [ID_W-1:0] lo;
         logic [ID_W-1:0] hi;
         logic [ID_W-1:0] cur;
         logic [ID_W-1:0] nx;
         int              n;
         case (m)
            MODE_INIT: relink();
            MODE_DUMP: begin
               cur = next_of[0];
               n = 0;
               while (cur != 0 && n < int'(count)) begin
                  nx = next_of[cur];
                  pending.push_back('{id: cur, last: (nx == 0 || n + 1 >= int'(count))});
                  n++;
                  cur = nx;
               end
            end
            default: begin
               if (el != 0 && el <= count) begin
                  lo = prev_of[el];
                  hi = next_of[el];
                  next_of[lo] = hi;
                  prev_of[hi] = lo;
                  if (m == MODE_LEFT) begin
                     hi = next_of[0];
                     prev_of[el] = '0;
                     next_of[el] = hi;
                     prev_of[hi] = el;
                     next_of[0] = el;
                  end else begin
                     lo = prev_of[0];
                     next_of[el] = '0;
                     prev_of[el] = lo;
                     next_of[lo] = el;
                     prev_of[0] = el;
                  end
               end
            end
         endcase
      endfunction

      function void check_result(logic [ID_W-1:0] id, logic last);
         dump_beat_type exp_beat;
         if (pending.size() == 0) begin
            $error("unexpected dump beat: element_id %0d is_last %0d", id, last);
            error_count++;
         end else begin
            exp_beat = pending.pop_front();
            if (id !== exp_beat.id) begin
               $error("element_id: expected %0d, actual %0d", exp_beat.id, id);
               error_count++;
            end
            if (last !== exp_beat.last) begin
               $error("is_last: expected %0d, actual %0d", exp_beat.last, last);
               error_count++;
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   bit                    idling_on = 1'b1;
   int                    quiet_cycles = 0;
   ordering_tracker       tracker = new();

   mtel_req_if req_bus();
   mtel_rsp_if rsp_bus();

   move_to_end_ordered_list dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   task automatic send_request(mode_type m, logic [ID_W-1:0] el);
      int gap;
      gap = idling_on ? $urandom_range(4) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= m;
      req_bus.element <= el;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_request(m, el);
   endtask

   // drop valid and let the block settle after the last dump beat
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == COUNT_ADDR) tracker.set_count(data);
   endtask

   task automatic send_random_item();
      int              r;
      logic [ID_W-1:0] el;
      r = $urandom_range(99);
      if (r < 60) begin
         send_request(mode_type'($urandom_range(1)),
                      ID_W'($urandom_range(1, int'(tracker.count))));
      end else if (r < 72) begin
         el = ($urandom_range(1) == 0) ? '0
              : ID_W'($urandom_range(int'(tracker.count) + 1, 127));
         send_request(mode_type'($urandom_range(1)), el);
      end else if (r < 92) begin
         send_request(MODE_DUMP, ID_W'($urandom()));
      end else begin
         send_request(MODE_INIT, ID_W'($urandom()));
      end
   endtask

   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = idling_on ? $urandom_range(4) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         tracker.check_result(rsp_bus.element_id, rsp_bus.is_last);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (psel === 1'b1 && penable === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] settings [PHASE_COUNT];
      logic [CSR_DATA_W-1:0] value;
      settings = '{1, 2, 0, 127, 3, 8, 0, 65, 64};
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_LEFT;
      req_bus.element <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(MODE_DUMP, 7'h7F);
      send_request(MODE_LEFT, 7'd64);
      send_request(MODE_RIGHT, 7'd1);
      send_request(MODE_LEFT, 7'd64);
      send_request(MODE_RIGHT, 7'd1);
      send_request(MODE_DUMP, 7'h00);
      send_request(MODE_LEFT, 7'd0);
      send_request(MODE_RIGHT, 7'd65);
      send_request(MODE_LEFT, 7'd127);
      send_request(MODE_RIGHT, 7'd64);
      send_request(MODE_LEFT, 7'd33);
      send_request(MODE_LEFT, 7'd42);
      send_request(MODE_RIGHT, 7'd85);
      send_request(MODE_DUMP, 7'h55);
      send_request(MODE_INIT, 7'h2A);
      send_request(MODE_DUMP, 7'h00);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         quiesce();
         if (ph == 4) csr_write(SPARE_ADDR, $urandom());
         value = (ph == 6) ? CSR_DATA_W'($urandom_range(1, MAX_ELEMENTS)) : settings[ph];
         csr_write(COUNT_ADDR, ($urandom() & ~32'h7F) | value);
         idling_on = (ph % 3 != 2);
         send_request(MODE_DUMP, ID_W'($urandom()));
         repeat (PHASE_ITEMS) send_random_item();
      end

      quiesce();
      if (tracker.error_count == 0 && tracker.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/mtel_pkg.sv
hw/rtl/mtel_ifs.sv
hw/rtl/mtel_ram.sv
hw/rtl/mtel_csr.sv
hw/rtl/mtel_seq.sv
hw/rtl/move_to_end_ordered_list.sv
hw/rtl/mtel_checker.sv
dv/tb_top.sv
